FILE: sv/cfbx_pkg.sv
// Shared types, constants and helpers for the command frame builder.
// No dependencies; used by all cfbx modules and the top level.
`timescale 1ns / 1ps

package cfbx_pkg;

  // Fixed frame header bytes
  localparam logic [7:0] HDR_M0 = 8'h23;  // '#'
  localparam logic [7:0] HDR_M1 = 8'h53;  // 'S'
  localparam logic [7:0] HDR_M2 = 8'h54;  // 'T'
  localparam logic [7:0] HDR_M3 = 8'h53;  // 'S'
  localparam logic [7:0] HDR_B4 = 8'h01;
  localparam logic [7:0] HDR_B5 = 8'hFE;

  localparam int unsigned HDR_LEN = 9;   // header bytes per frame
  localparam int unsigned STEP_W  = 4;   // enough for header plus checksum
  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_ERROR
  } cmd_kind_t;

  // One classified command, front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       chk;      // checksum follows this command's bytes
    logic [7:0] len;      // count + 2 (start)
    logic [7:0] grp;      // group (start)
    logic [7:0] ver;      // version (start)
    logic [7:0] data;     // payload byte (data)
  } cmd_t;

  // Header byte at position idx (0..HDR_LEN-1)
  function automatic logic [7:0] hdr_byte(input logic [STEP_W-1:0] idx,
                                          input logic [7:0] len,
                                          input logic [7:0] grp,
                                          input logic [7:0] ver);
    logic [7:0] b;
    begin
      unique case (idx)
        4'd0:    b = HDR_M0;
        4'd1:    b = HDR_M1;
        4'd2:    b = HDR_M2;
        4'd3:    b = HDR_M3;
        4'd4:    b = HDR_B4;
        4'd5:    b = HDR_B5;
        4'd6:    b = len;
        4'd7:    b = grp;
        4'd8:    b = ver;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

FILE: sv/cfbx_front.sv
// Front end: accepts input transactions and classifies them into commands.
// Tracks the payload bytes still expected. Depends on cfbx_pkg.
`timescale 1ns / 1ps

module cfbx_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            action,
  input  logic [7:0]      frame_group,
  input  logic [7:0]      frame_version,
  input  logic [7:0]      payload_count,
  input  logic [7:0]      payload_byte,
  input  logic            q_full,
  output logic            q_push,
  output cfbx_pkg::cmd_t  q_cmd
);

  logic [7:0] bytes_left;
  logic [7:0] bytes_left_next;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    bytes_left_next = bytes_left;
    q_cmd.len  = payload_count + 8'd2;
    q_cmd.grp  = frame_group;
    q_cmd.ver  = frame_version;
    q_cmd.data = payload_byte;
    q_cmd.kind = cfbx_pkg::CMD_ERROR;
    q_cmd.chk  = 1'b0;
    priority if (action == cfbx_pkg::ACT_START) begin
      q_cmd.kind      = cfbx_pkg::CMD_START;
      q_cmd.chk       = (payload_count == 8'd0);
      bytes_left_next = payload_count;
    end else if (bytes_left != 8'd0) begin
      q_cmd.kind      = cfbx_pkg::CMD_DATA;
      q_cmd.chk       = (bytes_left == 8'd1);
      bytes_left_next = bytes_left - 8'd1;
    end else begin
      // payload with no open frame: error, state unchanged
      q_cmd.kind = cfbx_pkg::CMD_ERROR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left <= 8'd0;
    end else if (q_push) begin
      bytes_left <= bytes_left_next;
    end
  end

endmodule

FILE: sv/cfbx_queue.sv
// Small command queue between front and back ends.
// Register-based ring buffer of cfbx_pkg::cmd_t entries.
`timescale 1ns / 1ps

module cfbx_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cfbx_pkg::cmd_t  push_cmd,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output cfbx_pkg::cmd_t  head
);

  cfbx_pkg::cmd_t                  mem [cfbx_pkg::QDEPTH];
  logic [cfbx_pkg::QPTR_W-1:0]     wr_ptr;
  logic [cfbx_pkg::QPTR_W-1:0]     rd_ptr;
  logic [cfbx_pkg::QCNT_W-1:0]     count;

  assign full  = (count == cfbx_pkg::QCNT_W'(cfbx_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: sv/cfbx_back.sv
// Back end: steps through each queued command one byte per cycle unless
// stalled, keeps the running XOR, drives the registered output; uses cfbx_pkg.
`timescale 1ns / 1ps

module cfbx_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cfbx_pkg::cmd_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic            out_error
);

  logic [cfbx_pkg::STEP_W-1:0] step;
  logic [7:0]                  running_xor;
  logic                        advance;
  logic                        final_step;
  logic                        is_chk;
  logic [7:0]                  byte_sel;

  assign advance = !q_empty && (!out_valid || out_ready);
  assign q_pop   = advance && final_step;

  always_comb begin
    final_step = 1'b0;
    is_chk     = 1'b0;
    byte_sel   = 8'h00;
    unique case (q_head.kind)
      cfbx_pkg::CMD_START: begin
        if (step < cfbx_pkg::STEP_W'(cfbx_pkg::HDR_LEN)) begin
          byte_sel   = cfbx_pkg::hdr_byte(step, q_head.len, q_head.grp, q_head.ver);
          final_step = (step == cfbx_pkg::STEP_W'(cfbx_pkg::HDR_LEN - 1)) && !q_head.chk;
        end else begin
          byte_sel   = ~running_xor;
          is_chk     = 1'b1;
          final_step = 1'b1;
        end
      end
      cfbx_pkg::CMD_DATA: begin
        if (step == '0) begin
          byte_sel   = q_head.data;
          final_step = !q_head.chk;
        end else begin
          byte_sel   = ~running_xor;
          is_chk     = 1'b1;
          final_step = 1'b1;
        end
      end
      default: begin
        byte_sel   = 8'h00;
        final_step = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= '0;
      running_xor <= 8'h00;
      out_valid   <= 1'b0;
    end else begin
      // stays valid until taken, reloads whenever a new byte advances
      out_valid <= advance || (out_valid && !out_ready);
      if (advance) begin
        step      <= final_step ? '0 : step + 1'b1;
        if (is_chk) begin
          running_xor <= 8'h00;
        end else if (q_head.kind == cfbx_pkg::CMD_START && step == '0) begin
          running_xor <= byte_sel;  // new frame restarts the checksum
        end else if (q_head.kind != cfbx_pkg::CMD_ERROR) begin
          running_xor <= running_xor ^ byte_sel;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte  <= byte_sel;
      out_last  <= is_chk;
      out_error <= (q_head.kind == cfbx_pkg::CMD_ERROR);
    end
  end

endmodule

FILE: sv/command_frame_builder_xor.sv
// Command frame builder with inverted-XOR checksum, streaming in and out.
// A transaction is written into the command queue, then into the output register.
// One output byte per cycle unless the output stalls; a start emits 9 header
// bytes, a payload byte 1, plus the checksum at frame end; one back-end sequencer.
// Input is taken every cycle while the 4-entry command queue has room.
// Reset (rst, synchronous): no frame open, queue and output empty.
`timescale 1ns / 1ps

module command_frame_builder_xor (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // frame_group[7:0], frame_version[15:8],
                                      // payload_count[23:16], payload_byte[31:24]
  input  logic        s_axis_tuser,   // action: 0 start frame, 1 payload byte
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte[7:0]
  output logic        m_axis_tlast,   // checksum byte, end of frame
  output logic        m_axis_tuser    // error: payload with no open frame
);

  // Front end -> queue
  logic           q_push;
  logic           q_full;
  cfbx_pkg::cmd_t q_cmd;

  // Queue -> back end
  logic           q_pop;
  logic           q_empty;
  cfbx_pkg::cmd_t q_head;

  // Front end: classifies each transaction as start, data or error and tracks
  // how many payload bytes the open frame still expects.
  cfbx_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .action        (s_axis_tuser),
    .frame_group   (s_axis_tdata[7:0]),
    .frame_version (s_axis_tdata[15:8]),
    .payload_count (s_axis_tdata[23:16]),
    .payload_byte  (s_axis_tdata[31:24]),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_cmd)
  );

  // Decouples input acceptance from the multi-byte output of a start.
  cfbx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back end: emits header, payload and checksum bytes into an output register.
  cfbx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .out_error (m_axis_tuser)
  );

endmodule
